FILE: src/hltfp_pkg.sv
// Shared constants, types and register codes for the header/length/tail frame parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hltfp_pkg;

    localparam int FRAME_DEPTH = 32;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_VALUE    = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hA1;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h1A;
    localparam logic [BYTE_W-1:0] TAIL_VALUE_RST    = 8'hAA;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } back_stat_t;

endpackage

FILE: src/hltfp_front.sv
// Front end: configuration registers, header/length/tail classification and store writes.
// Depends on hltfp_pkg.
`timescale 1ns / 1ps

module hltfp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hltfp_pkg::BYTE_W-1:0]        in_byte,
    input  logic                                cfg_wr_en,
    input  logic [hltfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hltfp_pkg::BYTE_W-1:0]        cfg_data,
    output hltfp_pkg::store_wr_t                store_wr,
    output logic                                cmd_push,
    output hltfp_pkg::cmd_t                     cmd,
    input  hltfp_pkg::fifo_stat_t               fifo_stat,
    input  hltfp_pkg::back_stat_t               back_stat
);

    logic [hltfp_pkg::BYTE_W-1:0] hf_reg, hf_next;
    logic [hltfp_pkg::BYTE_W-1:0] hs_reg, hs_next;
    logic [hltfp_pkg::BYTE_W-1:0] tail_reg, tail_next;
    logic [hltfp_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [hltfp_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                         armed_reg, armed_next;
    logic                         open_reg, open_next;
    logic                         wait_reg, wait_next;

    logic                         accept;
    logic                         hit1;
    logic                         hit2;
    logic                         store_req;
    logic                         full;
    logic [hltfp_pkg::IDX_W-1:0]  idx_inc;
    logic [hltfp_pkg::BYTE_W-1:0] eff_len;

    assign in_ready  = !fifo_stat.full && !wait_reg;
    assign accept    = in_valid && in_ready;
    assign hit1      = (in_byte == hf_reg);
    assign hit2      = !hit1 && (in_byte == hs_reg);
    assign store_req = hit1 || (hit2 && (armed_reg || open_reg)) || (!hit1 && !hit2 && open_reg);
    assign full      = (idx_reg == hltfp_pkg::IDX_W'(hltfp_pkg::FRAME_DEPTH));
    assign idx_inc   = idx_reg + hltfp_pkg::IDX_W'(1);
    assign eff_len   = (idx_reg == hltfp_pkg::IDX_W'(2)) ? in_byte : len_reg;

    always_comb
    begin
        hf_next    = hf_reg;
        hs_next    = hs_reg;
        tail_next  = tail_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        armed_next = armed_reg;
        open_next  = open_reg;
        wait_next  = wait_reg;
        store_wr.en   = 1'b0;
        store_wr.addr = idx_reg[hltfp_pkg::ADDR_W-1:0];
        store_wr.data = in_byte;
        cmd_push   = 1'b0;
        cmd.kind   = hltfp_pkg::KIND_FRAME;
        cmd.count  = idx_inc;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                hltfp_pkg::CFG_HEADER_FIRST:  hf_next   = cfg_data;
                hltfp_pkg::CFG_HEADER_SECOND: hs_next   = cfg_data;
                hltfp_pkg::CFG_TAIL_VALUE:    tail_next = cfg_data;
                default: ;
            endcase
        end

        if (back_stat.done)
        begin
            wait_next = 1'b0;
        end

        if (accept)
        begin
            if (store_req && full)
            begin
                cmd_push   = 1'b1;
                cmd.kind   = hltfp_pkg::KIND_ABORT;
                idx_next   = '0;
                armed_next = 1'b0;
                open_next  = 1'b0;
            end
            else if (store_req)
            begin
                store_wr.en = 1'b1;
                idx_next    = idx_inc;
                if (idx_reg == hltfp_pkg::IDX_W'(2))
                begin
                    len_next = in_byte;
                end
                if (hit1)
                begin
                    if (!open_reg)
                    begin
                        armed_next = 1'b1;
                    end
                end
                else if (hit2 && armed_reg)
                begin
                    open_next  = 1'b1;
                    armed_next = 1'b0;
                end
                else if (!hit2 && (8'(idx_inc) == eff_len) && (in_byte == tail_reg))
                begin
                    // frame complete: hand the count to the back end and hold input
                    cmd_push   = 1'b1;
                    wait_next  = 1'b1;
                    idx_next   = '0;
                    armed_next = 1'b0;
                    open_next  = 1'b0;
                end
            end
            else if (!hit1 && !hit2)
            begin
                idx_next   = '0;
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_reg    <= hltfp_pkg::HEADER_FIRST_RST;
            hs_reg    <= hltfp_pkg::HEADER_SECOND_RST;
            tail_reg  <= hltfp_pkg::TAIL_VALUE_RST;
            idx_reg   <= '0;
            armed_reg <= 1'b0;
            open_reg  <= 1'b0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            hf_reg    <= hf_next;
            hs_reg    <= hs_next;
            tail_reg  <= tail_next;
            idx_reg   <= idx_next;
            armed_reg <= armed_next;
            open_reg  <= open_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

FILE: src/hltfp_fifo.sv
// Two-entry command queue between the front end and the readout back end.
// Depends on hltfp_pkg.
`timescale 1ns / 1ps

module hltfp_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hltfp_pkg::cmd_t       push_cmd,
    input  logic                  pop,
    output hltfp_pkg::cmd_t       head_cmd,
    output hltfp_pkg::fifo_stat_t stat
);

    hltfp_pkg::cmd_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/hltfp_back.sv
// Back end: frame store memory, readout sequencer and output register.
// Depends on hltfp_pkg.
`timescale 1ns / 1ps

module hltfp_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hltfp_pkg::store_wr_t          store_wr,
    input  hltfp_pkg::cmd_t               head_cmd,
    input  hltfp_pkg::fifo_stat_t         fifo_stat,
    output logic                          pop,
    output hltfp_pkg::back_stat_t         stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output logic [hltfp_pkg::BYTE_W-1:0]  out_data,
    output logic                          out_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [hltfp_pkg::BYTE_W-1:0] mem [hltfp_pkg::FRAME_DEPTH];
    logic [hltfp_pkg::BYTE_W-1:0] rd_data_reg;

    logic [1:0]                   state_reg, state_next;
    logic [hltfp_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [hltfp_pkg::IDX_W-1:0]  count_reg, count_next;
    logic                         ovalid_reg, ovalid_next;
    logic                         okind_reg, okind_next;
    logic [hltfp_pkg::BYTE_W-1:0] odata_reg, odata_next;
    logic                         olast_reg, olast_next;

    logic                         slot_free;
    logic                         at_last;

    assign slot_free = !ovalid_reg || out_ready;
    assign at_last   = ({1'b0, addr_reg} == (count_reg - hltfp_pkg::IDX_W'(1)));
    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;
    assign stat.busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg && !out_ready;
        okind_next  = okind_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        pop         = 1'b0;
        stat.done   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    if (head_cmd.kind == hltfp_pkg::KIND_ABORT)
                    begin
                        if (slot_free)
                        begin
                            pop         = 1'b1;
                            ovalid_next = 1'b1;
                            okind_next  = hltfp_pkg::KIND_ABORT;
                            odata_next  = '0;
                            olast_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        addr_next  = '0;
                        count_next = head_cmd.count;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = hltfp_pkg::KIND_FRAME;
                    odata_next  = rd_data_reg;
                    olast_next  = at_last;
                    if (at_last)
                    begin
                        stat.done  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + hltfp_pkg::ADDR_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        count_reg <= count_next;
        okind_reg <= okind_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            mem[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= mem[addr_reg];
    end

endmodule

FILE: src/header_length_tail_frame_parser_core.sv
// Top level of the header/length/tail frame parser: front end, command queue, back end.
// Depends on hltfp_pkg, hltfp_front, hltfp_fifo and hltfp_back.
`timescale 1ns / 1ps

// Takes one received byte per beat and collects a frame that opens on two header bytes,
// carries a length byte at offset 2 and closes on a tail byte; the finished frame is sent
// out byte by byte with tlast on the final byte, and a store overflow gives one abort beat
// (tuser high, tdata zero, tlast high). A byte is accepted whenever the two-entry
// command queue has room and no frame readout is pending. A completed frame is read
// from the frame store byte by byte, each byte passing a fetch state for the registered
// read and then a send state that waits while the output register is stalled, and the
// input stays stalled from the completing byte until the final frame byte is in the
// output register. An abort beat leaves the queue once the output register is free.
// Configuration writes take effect at the next edge and are expected only while the
// block is idle.

module header_length_tail_frame_parser_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [hltfp_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [hltfp_pkg::BYTE_W-1:0]         m_axis_tdata,   // [7:0] byte_value
    output logic                                 m_axis_tuser,   // [0] result_kind
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [hltfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hltfp_pkg::BYTE_W-1:0]         cfg_data
);

    hltfp_pkg::store_wr_t   store_wr;
    hltfp_pkg::cmd_t        push_cmd;
    hltfp_pkg::cmd_t        head_cmd;
    hltfp_pkg::fifo_stat_t  fifo_stat;
    hltfp_pkg::back_stat_t  back_stat;
    logic                   cmd_push;
    logic                   cmd_pop;

    hltfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .store_wr  (store_wr),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd),
        .fifo_stat (fifo_stat),
        .back_stat (back_stat)
    );

    hltfp_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .stat     (fifo_stat)
    );

    hltfp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .store_wr  (store_wr),
        .head_cmd  (head_cmd),
        .fifo_stat (fifo_stat),
        .pop       (cmd_pop),
        .stat      (back_stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTH
    a_abort_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && m_axis_tlast))
        else $error("abort beat carries data or lacks tlast");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_stat.full)
        else $error("command pushed into a full queue");

    a_readout_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.busy && !back_stat.done) |-> !store_wr.en)
        else $error("frame store written during readout");

    a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.done |=> (m_axis_tvalid && m_axis_tlast && !m_axis_tuser))
        else $error("readout finished without a final frame beat");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for header_length_tail_frame_parser_core: a byte driver and a beat
// monitor around the block, checked against an in-bench frame parser predictor.
// Depends on hltfp_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    import hltfp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } frame_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    logic [BYTE_W-1:0] rx_pending[$];
    frame_beat_t       beats_due[$];
    logic              rx_taken = 1'b0;
    logic              steady = 1'b0;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    // predictor state
    logic [BYTE_W-1:0] hdr_first  = HEADER_FIRST_RST;
    logic [BYTE_W-1:0] hdr_second = HEADER_SECOND_RST;
    logic [BYTE_W-1:0] tail_byte  = TAIL_VALUE_RST;
    logic              copy_armed = 1'b0;
    logic              copy_open  = 1'b0;
    int                copy_index = 0;
    logic [BYTE_W-1:0] frame_copy[FRAME_DEPTH];

    header_length_tail_frame_parser_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit stash_byte(input logic [BYTE_W-1:0] b);
        if (copy_index >= FRAME_DEPTH)
            return 1'b0;
        frame_copy[copy_index] = b;
        copy_index++;
        return 1'b1;
    endfunction

    task automatic abort_frame();
        copy_armed = 1'b0;
        copy_open  = 1'b0;
        copy_index = 0;
        beats_due.push_back('{KIND_ABORT, '0, 1'b1});
    endtask

    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        int n;
        if (b == hdr_first)
        begin
            if (!copy_open)
                copy_armed = 1'b1;
            if (!stash_byte(b))
                abort_frame();
        end
        else if (b == hdr_second)
        begin
            if (copy_armed)
            begin
                copy_open  = 1'b1;
                copy_armed = 1'b0;
                if (!stash_byte(b))
                    abort_frame();
            end
            else if (copy_open)
            begin
                if (!stash_byte(b))
                    abort_frame();
            end
        end
        else if (!copy_open)
        begin
            copy_index = 0;
            copy_armed = 1'b0;
        end
        else if (!stash_byte(b))
            abort_frame();
        else if (copy_index == int'(frame_copy[2]) && b == tail_byte)
        begin
            n = copy_index;
            for (int i = 0; i < n; i++)
                beats_due.push_back('{KIND_FRAME, frame_copy[i], (i + 1 == n)});
            copy_armed = 1'b0;
            copy_open  = 1'b0;
            copy_index = 0;
        end
    endtask

    // byte driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || rx_taken)
        begin
            if (rx_pending.size() > 0 && (steady || $urandom_range(0, 99) >= 10))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_pending.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    // acceptance, prediction and beat check
    always @(posedge clk)
    begin
        frame_beat_t want;
        rx_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            parse_rx_byte(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (beats_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat kind=%0d data=%02h last=%0d", $time,
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = beats_due.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    mismatches++;
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                             m_axis_tuser);
                end
                if (m_axis_tdata !== want.value)
                begin
                    mismatches++;
                    $display("%0t: data expected %02h actual %02h", $time, want.value,
                             m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last,
                             m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout at %0t with %0d beats outstanding", $time, beats_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_idle();
        while (rx_pending.size() > 0 || s_axis_tvalid || beats_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_HEADER_FIRST:  hdr_first  = v;
            CFG_HEADER_SECOND: hdr_second = v;
            CFG_TAIL_VALUE:    tail_byte  = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] f, input logic [BYTE_W-1:0] s,
                               input logic [BYTE_W-1:0] t);
        wait_idle();
        write_reg(CFG_HEADER_FIRST, f);
        write_reg(CFG_HEADER_SECOND, s);
        write_reg(CFG_TAIL_VALUE, t);
    endtask

    // header pair, length byte, len-4 filler bytes, closing byte
    task automatic queue_frame(input int len, input logic [BYTE_W-1:0] closing);
        rx_pending.push_back(hdr_first);
        rx_pending.push_back(hdr_second);
        rx_pending.push_back(len[BYTE_W-1:0]);
        for (int i = 3; i < len - 1; i++)
            rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
        rx_pending.push_back(closing);
    endtask

    task automatic queue_traffic(input int count);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, FRAME_DEPTH)
                                                  : $urandom_range(4, 10);
                queue_frame(len, tail_byte);
                sent += len;
            end
            else if (pick < 75)
            begin
                // wrong closing byte, frame stays open
                len = $urandom_range(4, 12);
                queue_frame(len, tail_byte ^ BYTE_W'($urandom_range(1, 255)));
                sent += len;
            end
            else if (pick < 85)
            begin
                // length out of reach: runs into the overflow abort
                len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(FRAME_DEPTH + 1, 255);
                queue_frame(FRAME_DEPTH + 1, BYTE_W'($urandom_range(0, 255)));
                rx_pending[rx_pending.size() - FRAME_DEPTH + 1] = len[BYTE_W-1:0];
                sent += FRAME_DEPTH + 1;
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
                sent += len;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < FRAME_DEPTH; i++)
            frame_copy[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: noise, lone second header, shortest frame, headers inside a frame,
        // disarm by an ordinary byte, early tail byte
        rx_pending = '{8'h00, 8'hFF, 8'h1A,
                       8'hA1, 8'h1A, 8'h04, 8'hAA,
                       8'hA1, 8'h1A, 8'h06, 8'hA1, 8'h1A, 8'hAA,
                       8'hA1, 8'h5B,
                       8'hA1, 8'h1A, 8'h05, 8'hAA, 8'hAA};
        wait_idle();
        // repeated first header then overflow of the store
        rx_pending = '{8'hA1, 8'hA1, 8'h1A};
        for (int i = 0; i < FRAME_DEPTH - 2; i++)
            rx_pending.push_back(8'h00);
        wait_idle();
        queue_frame(FRAME_DEPTH, tail_byte);
        queue_traffic(30);

        set_markers(8'h00, 8'hFF, 8'h7F);
        write_reg(CFG_UNUSED, 8'h5A);
        steady = 1'b1;
        queue_traffic(25);
        wait_idle();
        steady = 1'b0;

        // tail equal to first header: frames can only overflow
        set_markers(8'hFF, 8'h00, 8'hFF);
        queue_traffic(20);

        // both headers equal: no frame ever opens
        set_markers(8'h55, 8'h55, 8'h00);
        for (int i = 0; i < FRAME_DEPTH + 1; i++)
            rx_pending.push_back(8'h55);
        queue_traffic(10);

        set_markers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                    BYTE_W'($urandom_range(0, 255)));
        queue_traffic(25);

        set_markers(HEADER_FIRST_RST, HEADER_SECOND_RST, TAIL_VALUE_RST);
        queue_traffic(20);

        while (rx_pending.size() > 0 || s_axis_tvalid || beats_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
src/hltfp_pkg.sv
src/hltfp_front.sv
src/hltfp_fifo.sv
src/hltfp_back.sv
src/header_length_tail_frame_parser_core.sv
tb/sv/testbench.sv
